// ===== rtl/core/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants of the pedal plausibility monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

	localparam int SAMPLE_W    = 10;
	localparam int PCT_W       = 7;
	localparam int TICKS_W     = 8;
	localparam int CFG_ADDR_W  = 3;
	localparam int CFG_DATA_W  = 10;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 24;

	localparam int THROTTLE_A_LSB = 0;
	localparam int THROTTLE_B_LSB = 10;
	localparam int BRAKE_RAW_LSB  = 20;

	localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

	localparam logic [SAMPLE_W-1:0] BRAKE_THRESHOLD_RST = 10'd15;
	localparam logic [SAMPLE_W-1:0] THROTTLE_HIGH_RST   = 10'd640;
	localparam logic [SAMPLE_W-1:0] THROTTLE_LOW_RST    = 10'd537;
	localparam logic [PCT_W-1:0]    AGREE_PERCENT_RST   = 7'd90;
	localparam logic [TICKS_W-1:0]  DISAGREE_TICKS_RST  = 8'd20;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_BRAKE_THRESHOLD = 3'd0,
		REG_THROTTLE_HIGH   = 3'd1,
		REG_THROTTLE_LOW    = 3'd2,
		REG_AGREE_PERCENT   = 3'd3,
		REG_DISAGREE_TICKS  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] brake_threshold;
		logic [SAMPLE_W-1:0] throttle_high;
		logic [SAMPLE_W-1:0] throttle_low;
		logic [PCT_W-1:0]    agree_percent;
		logic [TICKS_W-1:0]  disagree_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/ppm_div.sv =====
// ----------------------------------------------------------------------------
// ppm_div
// Unsigned division by a fixed divisor through a rounded-up reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_div #(
	parameter int IN_W    = 14,
	parameter int OUT_W   = 10,
	parameter int DIVISOR = 10
) (
	input  wire logic [IN_W-1:0]  num,
	output logic      [OUT_W-1:0] quo
);

	localparam int SH   = IN_W + $clog2(DIVISOR);
	localparam int M_W  = IN_W + 1;
	localparam int P_W  = IN_W + M_W;
	localparam logic [M_W-1:0] MULT = M_W'(((64'd1 << SH) + DIVISOR - 1) / DIVISOR);

	logic [P_W-1:0] prod;

	assign prod = P_W'(num) * P_W'(MULT);
	assign quo  = prod[SH +: OUT_W];

endmodule

`default_nettype wire

// ===== rtl/core/ppm_judge.sv =====
// ----------------------------------------------------------------------------
// ppm_judge
// Pedal agreement window, brake-throttle hysteresis and brake light decision.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_judge #(
	parameter int SW       = 10,
	parameter int ADC_BITS = 10
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ppm_pkg::cfg_t       cfg,
	input  wire logic                fire,
	input  wire logic                tick,
	input  wire logic [SW-1:0]       avg_a,
	input  wire logic [SW-1:0]       avg_b,
	input  wire logic [SW-1:0]       avg_brake,
	output logic                     light,
	output logic                     plausible
);

	localparam int IW = ADC_BITS + 1;
	localparam int PW = IW + ppm_pkg::PCT_W;
	localparam int TW = ppm_pkg::TICKS_W;

	logic          window_active_q;
	logic [TW-1:0] window_count_q;
	logic          pedals_agree_q;
	logic          brake_ok_q;

	logic [TW-1:0]                  limit;
	logic [TW-1:0]                  cnt_inc;
	logic [IW-1:0]                  inv_b;
	logic [IW-1:0]                  hi;
	logic [IW-1:0]                  lo;
	logic [PW-1:0]                  prod_lo;
	logic [PW-1:0]                  prod_hi;
	logic                           disagree;
	logic [ppm_pkg::SAMPLE_W-1:0]   a_ext;
	logic                           pa_nxt;
	logic                           bok_nxt;

	always_comb begin
		limit   = (cfg.disagree_ticks == '0) ? TW'(1) : cfg.disagree_ticks;
		cnt_inc = window_count_q + TW'(1);
		inv_b   = IW'(1 << ADC_BITS) - IW'(avg_b);
		if (inv_b > IW'(avg_a)) begin
			hi = inv_b;
			lo = IW'(avg_a);
		end else begin
			hi = IW'(avg_a);
			lo = inv_b;
		end
		prod_lo  = PW'(lo) * PW'(ppm_pkg::PCT_SCALE);
		prod_hi  = PW'(hi) * PW'(cfg.agree_percent);
		disagree = prod_lo < prod_hi;
		a_ext    = ppm_pkg::SAMPLE_W'(avg_a);
		light    = ppm_pkg::SAMPLE_W'(avg_brake) > cfg.brake_threshold;
		pa_nxt   = pedals_agree_q || (!disagree && !window_active_q);
		if (brake_ok_q) begin
			bok_nxt = !(light && (a_ext > cfg.throttle_high));
		end else begin
			bok_nxt = a_ext <= cfg.throttle_low;
		end
		plausible = pa_nxt && bok_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_active_q <= 1'b0;
			window_count_q  <= '0;
			pedals_agree_q  <= 1'b1;
			brake_ok_q      <= 1'b1;
		end else if (fire) begin
			if (tick) begin
				if (window_active_q) begin
					if (cnt_inc >= limit) begin
						pedals_agree_q  <= 1'b0;
						window_active_q <= 1'b0;
						window_count_q  <= '0;
					end else begin
						window_count_q <= cnt_inc;
					end
				end
			end else begin
				if (disagree) begin
					if (pedals_agree_q && !window_active_q) begin
						window_active_q <= 1'b1;
						window_count_q  <= '0;
					end
				end else if (window_active_q) begin
					window_active_q <= 1'b0;
					window_count_q  <= '0;
				end
				pedals_agree_q <= pa_nxt;
				brake_ok_q     <= bok_nxt;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/pedal_plausibility_monitor.sv =====
// ----------------------------------------------------------------------------
// pedal_plausibility_monitor
// Averages throttle and brake samples per group and checks pedal plausibility.
// ----------------------------------------------------------------------------
// A group's result passes the stage 1, stage 2 and result registers after the
// edge that accepts its last sample set; ticks and other sample sets give no result.
// Throughput: one item per cycle while input is not stalled; input, divide and judge
// stages each end in a register, and a waiting result stalls input only once both stages hold.
// Reset: asynchronous; sums, index, flags and config return to defaults, stage and result data do not.
`default_nettype none

module pedal_plausibility_monitor #(
	parameter int AVG_COUNT = 10,
	parameter int ADC_BITS  = 10
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ppm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  wire logic [ppm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// throttle_a[9:0], throttle_b[19:10], brake_raw[29:20], zero[31:30]
	input  wire logic [ppm_pkg::S_TDATA_W-1:0]      s_tdata,
	// mode[0]
	input  wire logic                               s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// throttle_avg[9:0], brake_avg[19:10], brake_light[20], plausible[21], zero[23:22]
	output logic      [ppm_pkg::M_TDATA_W-1:0]      m_tdata
);

	localparam int SW    = (ADC_BITS < ppm_pkg::SAMPLE_W) ? ADC_BITS : ppm_pkg::SAMPLE_W;
	localparam int IDX_W = $clog2(AVG_COUNT + 1);
	localparam int SUM_W = SW + IDX_W;
	localparam int AW    = ppm_pkg::SAMPLE_W;

	ppm_pkg::cfg_t cfg_q;

	logic [SUM_W-1:0] sum_a_q, sum_b_q, sum_brake_q;
	logic [IDX_W-1:0] idx_q;

	logic             v_s1, tick_s1;
	logic [SUM_W-1:0] sum_a_s1, sum_b_s1, sum_brake_s1;

	logic             v_s2, tick_s2;
	logic [SW-1:0]    avg_a_s2, avg_b_s2, avg_brake_s2;

	logic             m_tvalid_q;
	logic [AW-1:0]    out_throttle_q, out_brake_q;
	logic             out_light_q, out_plausible_q;

	logic             acc, last, load;
	logic [SUM_W-1:0] add_a, add_b, add_brake;
	logic [SW-1:0]    div_a, div_b, div_brake;
	logic             out_free, s2_fire, s2_ready;
	logic             light, plausible;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.brake_threshold <= ppm_pkg::BRAKE_THRESHOLD_RST;
			cfg_q.throttle_high   <= ppm_pkg::THROTTLE_HIGH_RST;
			cfg_q.throttle_low    <= ppm_pkg::THROTTLE_LOW_RST;
			cfg_q.agree_percent   <= ppm_pkg::AGREE_PERCENT_RST;
			cfg_q.disagree_ticks  <= ppm_pkg::DISAGREE_TICKS_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ppm_pkg::REG_BRAKE_THRESHOLD: cfg_q.brake_threshold <= cfg_data;
				ppm_pkg::REG_THROTTLE_HIGH:   cfg_q.throttle_high   <= cfg_data;
				ppm_pkg::REG_THROTTLE_LOW:    cfg_q.throttle_low    <= cfg_data;
				ppm_pkg::REG_AGREE_PERCENT:
					cfg_q.agree_percent <= cfg_data[ppm_pkg::PCT_W-1:0];
				ppm_pkg::REG_DISAGREE_TICKS:
					cfg_q.disagree_ticks <= cfg_data[ppm_pkg::TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign out_free = !m_tvalid_q || m_tready;
	assign s2_fire  = v_s2 && (tick_s2 || out_free);
	assign s2_ready = !v_s2 || s2_fire;
	assign s_tready = !v_s1 || s2_ready;

	assign acc  = s_tvalid && s_tready;
	assign last = idx_q == IDX_W'(AVG_COUNT - 1);
	assign load = acc && (s_tuser || last);

	assign add_a     = sum_a_q + SUM_W'(s_tdata[ppm_pkg::THROTTLE_A_LSB +: SW]);
	assign add_b     = sum_b_q + SUM_W'(s_tdata[ppm_pkg::THROTTLE_B_LSB +: SW]);
	assign add_brake = sum_brake_q + SUM_W'(s_tdata[ppm_pkg::BRAKE_RAW_LSB +: SW]);

	// accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			sum_brake_q <= '0;
			idx_q       <= '0;
		end else if (acc && !s_tuser) begin
			if (last) begin
				sum_a_q     <= '0;
				sum_b_q     <= '0;
				sum_brake_q <= '0;
				idx_q       <= '0;
			end else begin
				sum_a_q     <= add_a;
				sum_b_q     <= add_b;
				sum_brake_q <= add_brake;
				idx_q       <= idx_q + IDX_W'(1);
			end
		end
	end

	// stage 1: finished sums or tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (s2_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tick_s1      <= s_tuser;
			sum_a_s1     <= add_a;
			sum_b_s1     <= add_b;
			sum_brake_s1 <= add_brake;
		end
	end

	ppm_div #(.IN_W(SUM_W), .OUT_W(SW), .DIVISOR(AVG_COUNT)) u_div_a (
		.num (sum_a_s1),
		.quo (div_a)
	);

	ppm_div #(.IN_W(SUM_W), .OUT_W(SW), .DIVISOR(AVG_COUNT)) u_div_b (
		.num (sum_b_s1),
		.quo (div_b)
	);

	ppm_div #(.IN_W(SUM_W), .OUT_W(SW), .DIVISOR(AVG_COUNT)) u_div_brake (
		.num (sum_brake_s1),
		.quo (div_brake)
	);

	// stage 2: averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			tick_s2      <= tick_s1;
			avg_a_s2     <= div_a;
			avg_b_s2     <= div_b;
			avg_brake_s2 <= div_brake;
		end
	end

	ppm_judge #(.SW(SW), .ADC_BITS(ADC_BITS)) u_judge (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fire      (s2_fire),
		.tick      (tick_s2),
		.avg_a     (avg_a_s2),
		.avg_b     (avg_b_s2),
		.avg_brake (avg_brake_s2),
		.light     (light),
		.plausible (plausible)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s2_fire && !tick_s2) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire && !tick_s2) begin
			out_throttle_q  <= AW'(avg_a_s2);
			out_brake_q     <= AW'(avg_brake_s2);
			out_light_q     <= light;
			out_plausible_q <= plausible;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_plausible_q, out_light_q, out_brake_q, out_throttle_q};

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(AVG_COUNT))
		else $error("sample index past group size");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stalled with empty first stage");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s2 && !tick_s2))
		else $error("result without a finished group");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(s2_fire && !tick_s2))
		else $error("waiting result overwritten");
`endif

endmodule

`default_nettype wire
